/* hw/rtl/kji_pkg.sv */
// Shared constants and codes for the keyframe joint interpolator.
`default_nettype none
package kji_pkg;

  localparam int JOINTS      = 9;
  localparam int FRAMES_DEF  = 8;
  localparam int ANGLE_W_DEF = 26;

  localparam int CMD_W       = 2;
  localparam int FRAME_IDX_W = 3;
  localparam int JOINT_IDX_W = 4;
  localparam int STEPS_W     = 10;
  localparam int SEG_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'd1;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd80;
  localparam logic [SEG_W-1:0]   LAST_RESET  = 3'd6;

endpackage
`default_nettype wire

/* hw/rtl/kji_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kji_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 72
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/keyframe_joint_interpolator_unit.sv */
// Top level of the keyframe joint interpolator with its sequencer and shared divider.
//
// Input beats arrive on the s_axis channel: tuser carries the command (tick, play toggle,
// load one keyframe angle) and tdata the load fields. Every input beat yields exactly one
// output beat on m_axis carrying all nine joint angles, the playing flag and the segment.
// Configuration (steps per segment, last segment) is written through cfg_we_i/cfg_idx_i.
// A load or a stop goes straight to the output state; a plain tick of the angles first
// runs the nine angle updates one joint a cycle through a single saturating adder.
// A play start or a segment advance recomputes the nine increments joint by joint:
// each joint reads two keyframe entries from the store RAM, one after the other, and
// then one restoring divider produces its increment one quotient bit per cycle.
// The input is not ready while a beat is being worked on. A result waiting on a stalled
// receiver does not block the next input beat; the sequencer only waits at the end of
// that next beat until the output register is free.
// Reset stops playback, clears angles, increments, counters and the output valid, and
// restores the register defaults; the keyframe store holds garbage until it is loaded.
`default_nettype none
module keyframe_joint_interpolator_unit
  import kji_pkg::*;
#(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int ANGLE_WIDTH = ANGLE_W_DEF,
  localparam int IN_W  = ((FRAME_IDX_W + JOINT_IDX_W + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((JOINTS * ANGLE_WIDTH + 1 + SEG_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // frame_index, joint_index, angle_value (lowest bits first), zero padded
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // command
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // elbow, thumb base, thumb tip, index base, index mid, index tip, ring base,
  // ring mid, ring tip angles, playing, segment (lowest bits first), zero padded
  output logic [OUT_W-1:0]           m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW     = ANGLE_WIDTH;
  localparam int DW     = AW + 1;
  localparam int DEPTH  = FRAMES * JOINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int CALC_W = 10;

  localparam logic [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [DW-1:0] HALF = DW'(1) << (AW - 1);
  localparam logic [6:0]    FR7  = 7'(FRAMES);
  localparam logic [JOINT_IDX_W-1:0] LAST_JOINT = JOINT_IDX_W'(JOINTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_CUR = 3'd1;
  localparam logic [2:0] S_RD_NXT = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // Reduce a small segment number modulo FRAMES by repeated subtraction.
  function automatic logic [3:0] frame_wrap(input logic [3:0] v);
    logic [6:0] r;
    r = {3'b000, v};
    for (int k = 0; k < 4; k++) begin
      if (r >= FR7) begin
        r = r - FR7;
      end
    end
    return r[3:0];
  endfunction

  logic [2:0]             state_q, state_d;
  logic [STEPS_W-1:0]     steps_q, steps_d;
  logic [SEG_W-1:0]       last_q, last_d;
  logic [STEPS_W-1:0]     step_q, step_d;
  logic [SEG_W-1:0]       seg_q, seg_d;
  logic                   playing_q, playing_d;
  logic                   copy_q, copy_d;
  logic [JOINT_IDX_W-1:0] joint_q, joint_d;
  logic [AW-1:0]          angle_q [JOINTS];
  logic [AW-1:0]          angle_d [JOINTS];
  logic [AW-1:0]          incr_q  [JOINTS];
  logic [AW-1:0]          incr_d  [JOINTS];
  logic [AW-1:0]          cur_q, cur_d;
  logic                   neg_q, neg_d;
  logic [DW-1:0]          div_q, div_d;
  logic [STEPS_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_W-1:0]       m_data_q, m_data_d;

  logic [FRAME_IDX_W-1:0] in_frame;
  logic [JOINT_IDX_W-1:0] in_joint;
  logic [AW-1:0]          in_angle;
  logic                   in_accept;
  logic [STEPS_W-1:0]     eff_steps;
  logic [3:0]             cur_frame, nxt_frame;
  logic [CALC_W-1:0]      waddr_calc, raddr_calc;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [AW-1:0]          ram_rdata;
  logic [DW-1:0]          diff, mag;
  logic [STEPS_W:0]       trial;
  logic [DW-1:0]          sum;
  logic [AW-1:0]          quot_sat, sum_sat;
  logic [SEG_W:0]         seg_next;

  assign in_frame  = s_axis_tdata[FRAME_IDX_W-1:0];
  assign in_joint  = s_axis_tdata[FRAME_IDX_W +: JOINT_IDX_W];
  assign in_angle  = s_axis_tdata[FRAME_IDX_W + JOINT_IDX_W +: AW];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign eff_steps = (steps_q == '0) ? STEPS_W'(1) : steps_q;
  assign seg_next  = {1'b0, seg_q} + 4'd1;

  assign cur_frame = frame_wrap({1'b0, seg_q});
  assign nxt_frame = frame_wrap(seg_next);

  assign waddr_calc = CALC_W'({in_frame, 3'b000}) + CALC_W'(in_frame) + CALC_W'(in_joint);
  assign ram_we = in_accept && (s_axis_tuser == CMD_LOAD) && (int'(in_frame) < FRAMES) &&
                  (int'(in_joint) < JOINTS);

  always_comb begin
    if (state_q == S_RD_NXT) begin
      raddr_calc = CALC_W'({nxt_frame, 3'b000}) + CALC_W'(nxt_frame) + CALC_W'(joint_q);
    end else begin
      raddr_calc = CALC_W'({cur_frame, 3'b000}) + CALC_W'(cur_frame) + CALC_W'(joint_q);
    end
  end
  assign ram_raddr = raddr_calc[ADDR_W-1:0];

  kji_ram #(
    .WIDTH(AW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_calc[ADDR_W-1:0]),
    .wdata_i(in_angle),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Difference of the next and current keyframe entries, and its magnitude.
  assign diff  = {ram_rdata[AW-1], ram_rdata} - {cur_q[AW-1], cur_q};
  assign mag   = diff[DW-1] ? (DW'(0) - diff) : diff;
  assign trial = {rem_q, div_q[DW-1]};

  always_comb begin
    if (!neg_q) begin
      quot_sat = (div_q > {1'b0, AMAX}) ? AMAX : div_q[AW-1:0];
    end else begin
      quot_sat = (div_q > HALF) ? AMIN : AW'(DW'(0) - div_q);
    end
  end

  assign sum = {angle_q[joint_q][AW-1], angle_q[joint_q]} +
               {incr_q[joint_q][AW-1], incr_q[joint_q]};
  always_comb begin
    if (sum[DW-1] != sum[DW-2]) begin
      sum_sat = sum[DW-1] ? AMIN : AMAX;
    end else begin
      sum_sat = sum[AW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    steps_d   = steps_q;
    last_d    = last_q;
    step_d    = step_q;
    seg_d     = seg_q;
    playing_d = playing_q;
    copy_d    = copy_q;
    joint_d   = joint_q;
    angle_d   = angle_q;
    incr_d    = incr_q;
    cur_d     = cur_q;
    neg_d     = neg_q;
    div_d     = div_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEPS: steps_d = cfg_wdata_i[STEPS_W-1:0];
        REG_LAST:  last_d  = cfg_wdata_i[SEG_W-1:0];
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_OUT;
          joint_d = '0;
          case (s_axis_tuser)
            CMD_TOGGLE: begin
              if (!playing_q) begin
                playing_d = 1'b1;
                seg_d     = '0;
                step_d    = '0;
                copy_d    = 1'b1;
                state_d   = S_RD_CUR;
              end else begin
                playing_d = 1'b0;
              end
            end
            CMD_TICK: begin
              if (playing_q) begin
                if (step_q >= eff_steps) begin
                  if (seg_next > {1'b0, last_q}) begin
                    seg_d     = '0;
                    playing_d = 1'b0;
                  end else begin
                    seg_d   = seg_next[SEG_W-1:0];
                    step_d  = '0;
                    copy_d  = 1'b0;
                    state_d = S_RD_CUR;
                  end
                end else begin
                  step_d  = step_q + STEPS_W'(1);
                  state_d = S_ADD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_CUR: begin
        state_d = S_RD_NXT;
      end
      S_RD_NXT: begin
        cur_d = ram_rdata;
        if (copy_q) begin
          angle_d[joint_q] = ram_rdata;
        end
        state_d = S_DIFF;
      end
      S_DIFF: begin
        neg_d   = diff[DW-1];
        div_d   = mag;
        rem_d   = '0;
        cnt_d   = CNT_W'(DW);
        state_d = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial >= {1'b0, eff_steps}) begin
          rem_d = STEPS_W'(trial - {1'b0, eff_steps});
          div_d = {div_q[DW-2:0], 1'b1};
        end else begin
          rem_d = trial[STEPS_W-1:0];
          div_d = {div_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        incr_d[joint_q] = quot_sat;
        if (joint_q == LAST_JOINT) begin
          state_d = S_OUT;
        end else begin
          joint_d = joint_q + JOINT_IDX_W'(1);
          state_d = S_RD_CUR;
        end
      end
      S_ADD: begin
        angle_d[joint_q] = sum_sat;
        if (joint_q == LAST_JOINT) begin
          state_d = S_OUT;
        end else begin
          joint_d = joint_q + JOINT_IDX_W'(1);
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d = '0;
          for (int j = 0; j < JOINTS; j++) begin
            m_data_d[j*AW +: AW] = angle_q[j];
          end
          m_data_d[JOINTS*AW]               = playing_q;
          m_data_d[JOINTS*AW + 1 +: SEG_W]  = seg_q;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      steps_q   <= STEPS_RESET;
      last_q    <= LAST_RESET;
      step_q    <= '0;
      seg_q     <= '0;
      playing_q <= 1'b0;
      copy_q    <= 1'b0;
      joint_q   <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      for (int j = 0; j < JOINTS; j++) begin
        angle_q[j] <= '0;
        incr_q[j]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      steps_q   <= steps_d;
      last_q    <= last_d;
      step_q    <= step_d;
      seg_q     <= seg_d;
      playing_q <= playing_d;
      copy_q    <= copy_d;
      joint_q   <= joint_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      angle_q   <= angle_d;
      incr_q    <= incr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    neg_q    <= neg_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

/* hw/rtl/kji_checker.sv */
// Port-level checks on the keyframe joint interpolator and their binding.
`default_nettype none
module kji_checker
  import kji_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_W_DEF,
  localparam int OUT_W = ((JOINTS * ANGLE_WIDTH + 1 + SEG_W + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // The input is never ready in the cycle after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed or dropped");

  // While idle with no result pending, no new result appears unless an input beat is taken.
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && s_axis_tready && !(s_axis_tvalid && s_axis_tready))
      |=> !m_axis_tvalid)
    else $error("output beat without an input beat");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind keyframe_joint_interpolator_unit kji_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_kji_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
